@@ rtl/ucho_pkg.sv @@
// Shared types and constants of the unison chorus: voice table entries,
// configuration register indexes and the sequencer state encoding.
// Depends on nothing.
`timescale 1ns / 1ps

package ucho_pkg;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_VOICE_COUNT   = 2'd0;
	localparam cfg_idx_t CFG_UPDATE_PERIOD = 2'd1;
	localparam cfg_idx_t CFG_AMPLITUDE     = 2'd2;
	localparam cfg_idx_t CFG_OUTPUT_GAIN   = 2'd3;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// Oscillator part of a voice entry, written by voice loads and LFO updates.
	typedef struct packed {
		logic signed [15:0] pos;
		logic signed [15:0] step;
		logic [15:0]        amp;
	} voice_lfo_t;

	// Delay glide part of a voice entry, Q12.8 samples.
	typedef struct packed {
		logic [19:0] dfrom;
		logic [19:0] dto;
	} voice_glide_t;

	typedef enum logic [21:0] {
		S_IDLE   = 22'h000001,
		S_U_RD   = 22'h000002,
		S_U_ADD  = 22'h000004,
		S_U_SQ   = 22'h000008,
		S_U_CUBE = 22'h000010,
		S_U_H    = 22'h000020,
		S_U_AM   = 22'h000040,
		S_U_PLO  = 22'h000080,
		S_U_PHI  = 22'h000100,
		S_U_SUM  = 22'h000200,
		S_U_WR   = 22'h000400,
		S_G_RD   = 22'h000800,
		S_G_M0   = 22'h001000,
		S_G_M1   = 22'h002000,
		S_G_DIV  = 22'h004000,
		S_G_ADR  = 22'h008000,
		S_G_R0   = 22'h010000,
		S_G_R1   = 22'h020000,
		S_G_M2   = 22'h040000,
		S_G_M3   = 22'h080000,
		S_F_GAIN = 22'h100000,
		S_F_OUT  = 22'h200000
	} state_t;

endpackage

@@ rtl/unison_chorus.sv @@
// Unison chorus top level: delay store, voice tables and the sequencer.
// Depends on ucho_pkg for the voice entry types, register indexes and states.
`timescale 1ns / 1ps

// How to use this block:
// Items enter on the in_valid/in_ready channel. An item with op clear is an
// audio sample and yields exactly one sample_out item on out_valid/out_ready;
// an item with op set loads the oscillator entry of one voice and yields none.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. cfg_ready is always high. A voice load is taken in the
// idle state and leaves the block idle. For each active voice, an audio
// sample goes through a read of the two voice tables, a bit-serial divider
// that finds its fractional delay, two reads of the delay store and the
// weighting into the mix, then through the gain and output steps; on samples
// where the oscillators advance, every active voice is first updated.
// One item is worked on at a time: in_ready is high only in the idle state.
// The result sits in an output register, so a new item is accepted while it
// waits; if the receiver still stalls when the next result is ready, the
// block holds in its last step until the register frees.
// Reset clears the control state and the registers to their defaults. The
// delay store is not swept: a fill mark tells which entries were written,
// and the others read as zero. Voice table entries read as zero until first
// written, through one valid flag per voice in each table.
module unison_chorus #(
	parameter int DELAY_DEPTH = 4096,
	parameter int VOICES      = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  ucho_pkg::cfg_idx_t            cfg_index,
	input  logic [19:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [2:0]                    voice_index,
	input  logic signed [15:0]            voice_phase,
	input  logic signed [15:0]            voice_rate,
	input  logic [15:0]                   voice_amplitude,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam int AW   = $clog2(DELAY_DEPTH);
	localparam int KW   = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int ACCW = SAMPLE_BITS + 18 + KW + 1;
	localparam int GW   = ACCW + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
	localparam logic signed [GW-1:0] SAT_HI = GW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [GW-1:0] SAT_LO = -SAT_HI - GW'(1);

	// Configuration registers.
	logic [3:0]  voice_count_q;
	logic [15:0] update_period_q;
	logic [19:0] amplitude_q;
	logic [15:0] gain_q;

	// Sequencer and sample state.
	ucho_pkg::state_t state_q;
	logic [KW-1:0]    k_q;
	logic [AW-1:0]    wi_q;
	logic             wrapped_q;
	logic [15:0]      since_q;
	logic             first_q;
	logic [15:0]      per_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	// Memories.
	ucho_pkg::voice_lfo_t   lfo_mem   [VOICES];
	ucho_pkg::voice_glide_t glide_mem [VOICES];
	logic signed [SAMPLE_BITS-1:0] store_mem [DELAY_DEPTH];
	ucho_pkg::voice_lfo_t   va_q;
	ucho_pkg::voice_glide_t vb_q;
	logic                   va_ok_q, vb_ok_q;
	logic [VOICES-1:0]      lfo_ok_q, glide_ok_q;
	ucho_pkg::voice_lfo_t   va;
	ucho_pkg::voice_glide_t vb;
	logic signed [SAMPLE_BITS-1:0] st_rd_q;
	logic                   st_ok_q;

	// Oscillator update datapath.
	logic signed [15:0] p_q, st_q;
	logic signed [31:0] sq_q;
	logic signed [47:0] cube_q;
	logic [16:0]        h_q;
	logic [35:0]        m1_q;
	logic [34:0]        plo_q, phi_q;
	logic [52:0]        prod_q;

	// Glide and mixing datapath.
	logic [35:0]        mf_q;
	logic [15:0]        rem_q;
	logic [27:0]        sr_q;
	logic [4:0]         cnt_q;
	logic [AW-1:0]      i0_q, i1_q;
	logic [16:0]        w0_q, w1_q;
	logic signed [SAMPLE_BITS-1:0] s0_q, s1_q;
	logic signed [SAMPLE_BITS+17:0] v0_q;
	logic signed [ACCW-1:0] acc_q;
	logic signed [GW-1:0]   g_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                   out_valid_q;

	logic [KW-1:0] last_k;
	logic          in_acc;
	logic          lfo_we, glide_we, store_we;
	logic [KW-1:0] lfo_wa;
	ucho_pkg::voice_lfo_t   lfo_wd;
	ucho_pkg::voice_glide_t glide_wd;
	logic [AW-1:0] st_raddr;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ucho_pkg::S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;

	// Voice entries that were never written read as zero.
	assign va = va_ok_q ? va_q : '0;
	assign vb = vb_ok_q ? vb_q : '0;

	// Last active voice: the count is clamped to 1..VOICES.
	always_comb begin
		int n;
		n = int'(voice_count_q);
		if (n < 1) n = 1;
		if (n > VOICES) n = VOICES;
		last_k = KW'(n - 1);
	end

	// Oscillator step with reflection at the ends of the range.
	logic signed [16:0] p_sum;
	logic signed [15:0] p_new, st_new;
	always_comb begin
		p_sum  = 17'(va.pos) + 17'(va.step);
		p_new  = p_sum[15:0];
		st_new = va.step;
		if (p_sum <= -17'sd32768 || p_sum >= 17'sd32767) begin
			p_new  = (p_sum <= -17'sd32768) ? -16'sd32768 : 16'sd32767;
			st_new = (va.step == -16'sd32768) ? 16'sd32767 : -va.step;
		end
	end

	// Smoothed position (3p - p^3) mapped to 0..1 in Q16.
	logic signed [49:0] pw, tcurve, hsum;
	always_comb begin
		pw     = 50'(p_q);
		tcurve = ((pw * 50'sd3) <<< 30) - 50'(cube_q);
		hsum   = tcurve + (50'sd1 <<< 46);
	end

	// New delay target: 1 sample plus the rounded modulation, saturated.
	logic [52:0] prod_rnd;
	logic [23:0] tgt24;
	logic [19:0] tgt;
	always_comb begin
		prod_rnd = prod_q + (53'd1 << 29);
		tgt24    = 24'(prod_rnd[52:30]) + 24'd256;
		tgt      = (tgt24 > 24'hFFFFF) ? 20'hFFFFF : tgt24[19:0];
	end

	// Divider step and numerator.
	logic [35:0] num;
	logic [16:0] dtrial;
	logic        dge;
	always_comb begin
		num    = mf_q + 36'(vb.dto) * 36'(since_q);
		dtrial = {rem_q, sr_q[27]};
		dge    = (dtrial >= {1'b0, per_q});
	end

	// Read positions and interpolation weights from the Q.16 delay.
	logic [28:0]   dq;
	logic [15:0]   dfrac;
	logic [AW-1:0] di, base, i0n, i1n;
	logic [16:0]   w1n;
	always_comb begin
		int xr;
		dq = 29'(sr_q) + 29'h10000;
		dfrac = dq[15:0];
		xr = int'(dq[28:16]);
		for (int j = 5; j >= 0; j--) begin
			if (xr >= (DELAY_DEPTH << j)) xr = xr - (DELAY_DEPTH << j);
		end
		di = AW'(xr);
		if (wi_q >= di) base = wi_q - di;
		else base = AW'((AW+1)'(wi_q) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(di));
		i0n = base;
		w1n = 17'd0;
		if (dfrac != 16'd0) begin
			i0n = (base == '0) ? LAST_ADDR : base - AW'(1);
			w1n = 17'h10000 - 17'(dfrac);
		end
		i1n = (i0n == LAST_ADDR) ? '0 : i0n + AW'(1);
	end

	// Weighted tap of the second read, and the output rounding and clipping.
	logic signed [SAMPLE_BITS+17:0] v1, vsum;
	logic signed [ACCW-17:0] mixsum;
	logic signed [GW-1:0]    yr, ysh;
	logic signed [SAMPLE_BITS-1:0] ysat;
	always_comb begin
		v1     = $signed({1'b0, w1_q}) * s1_q;
		vsum   = v0_q + v1;
		mixsum = acc_q[ACCW-1:16];
		yr     = g_q + (GW'(1) <<< 14);
		ysh    = yr >>> 15;
		if (ysh > SAT_HI) ysat = SAT_HI[SAMPLE_BITS-1:0];
		else if (ysh < SAT_LO) ysat = SAT_LO[SAMPLE_BITS-1:0];
		else ysat = ysh[SAMPLE_BITS-1:0];
	end

	// Memory write controls.
	always_comb begin
		lfo_we   = 1'b0;
		glide_we = 1'b0;
		store_we = 1'b0;
		lfo_wa   = k_q;
		lfo_wd   = '{pos: p_q, step: st_q, amp: va.amp};
		glide_wd = '{dfrom: first_q ? tgt : vb.dto, dto: tgt};
		if (state_q == ucho_pkg::S_IDLE && in_acc && op == ucho_pkg::OP_LOAD
				&& 32'(voice_index) < VOICES) begin
			lfo_we = 1'b1;
			lfo_wa = KW'(voice_index);
			lfo_wd = '{pos: voice_phase, step: voice_rate, amp: voice_amplitude};
		end
		if (state_q == ucho_pkg::S_U_WR) begin
			lfo_we   = 1'b1;
			glide_we = 1'b1;
		end
		if (state_q == ucho_pkg::S_F_OUT && (!out_valid_q || out_ready)) begin
			store_we = 1'b1;
		end
		st_raddr = (state_q == ucho_pkg::S_G_R0) ? i0_q : i1_q;
	end

	// Voice tables: one read port addressed by the voice counter.
	always_ff @(posedge clk) begin
		if (lfo_we) lfo_mem[lfo_wa] <= lfo_wd;
		if (glide_we) glide_mem[k_q] <= glide_wd;
		va_q    <= lfo_mem[k_q];
		vb_q    <= glide_mem[k_q];
		va_ok_q <= lfo_ok_q[k_q];
		vb_ok_q <= glide_ok_q[k_q];
	end

	// Written flags of the voice table entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_ok_q   <= '0;
			glide_ok_q <= '0;
		end else begin
			if (lfo_we) lfo_ok_q[lfo_wa] <= 1'b1;
			if (glide_we) glide_ok_q[k_q] <= 1'b1;
		end
	end

	// Delay store; entries not yet written since reset read as zero.
	always_ff @(posedge clk) begin
		if (store_we) store_mem[wi_q] <= sample_q;
		st_rd_q <= store_mem[st_raddr];
		st_ok_q <= wrapped_q || (st_raddr < wi_q);
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ucho_pkg::S_IDLE: begin
				sample_q <= sample_in;
				per_q    <= (update_period_q == 16'd0) ? 16'd1 : update_period_q;
				acc_q    <= '0;
			end
			ucho_pkg::S_U_ADD: begin
				p_q  <= p_new;
				st_q <= st_new;
			end
			ucho_pkg::S_U_SQ:   sq_q   <= p_q * p_q;
			ucho_pkg::S_U_CUBE: cube_q <= 48'(sq_q) * 48'(p_q);
			ucho_pkg::S_U_H:    h_q    <= hsum[47:31];
			ucho_pkg::S_U_AM:   m1_q   <= 36'(amplitude_q) * 36'(va.amp);
			ucho_pkg::S_U_PLO:  plo_q  <= 35'(m1_q[17:0]) * 35'(h_q);
			ucho_pkg::S_U_PHI:  phi_q  <= 35'(m1_q[35:18]) * 35'(h_q);
			ucho_pkg::S_U_SUM:  prod_q <= {phi_q, 18'd0} + 53'(plo_q);
			ucho_pkg::S_G_M0:   mf_q   <= 36'(vb.dfrom) * 36'(per_q - since_q);
			ucho_pkg::S_G_M1: begin
				rem_q <= num[35:20];
				sr_q  <= {num[19:0], 8'd0};
			end
			ucho_pkg::S_G_DIV: begin
				rem_q <= dge ? 16'(dtrial - {1'b0, per_q}) : dtrial[15:0];
				sr_q  <= {sr_q[26:0], dge};
			end
			ucho_pkg::S_G_ADR: begin
				i0_q <= i0n;
				i1_q <= i1n;
				w1_q <= w1n;
				w0_q <= 17'h10000 - w1n;
			end
			ucho_pkg::S_G_R1: s0_q <= st_ok_q ? st_rd_q : '0;
			ucho_pkg::S_G_M2: begin
				s1_q <= st_ok_q ? st_rd_q : '0;
				v0_q <= $signed({1'b0, w0_q}) * s0_q;
			end
			ucho_pkg::S_G_M3: begin
				// Odd voices enter the mix with negative sign.
				acc_q <= k_q[0] ? acc_q - ACCW'(vsum) : acc_q + ACCW'(vsum);
			end
			ucho_pkg::S_F_GAIN: g_q <= mixsum * $signed({1'b0, gain_q});
			default: begin
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ucho_pkg::S_IDLE;
			k_q             <= '0;
			cnt_q           <= '0;
			wi_q            <= '0;
			wrapped_q       <= 1'b0;
			since_q         <= '0;
			first_q         <= 1'b1;
			out_valid_q     <= 1'b0;
			out_q           <= '0;
			voice_count_q   <= 4'd1;
			update_period_q <= 16'd64;
			amplitude_q     <= '0;
			gain_q          <= 16'd32768;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ucho_pkg::CFG_VOICE_COUNT:   voice_count_q   <= cfg_data[3:0];
					ucho_pkg::CFG_UPDATE_PERIOD: update_period_q <= cfg_data[15:0];
					ucho_pkg::CFG_AMPLITUDE:     amplitude_q     <= cfg_data;
					ucho_pkg::CFG_OUTPUT_GAIN:   gain_q          <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			// The last step reloads the output register itself.
			if (out_valid_q && out_ready && state_q != ucho_pkg::S_F_OUT)
				out_valid_q <= 1'b0;

			case (state_q)
				ucho_pkg::S_IDLE: begin
					k_q <= '0;
					if (in_acc) begin
						if (op == ucho_pkg::OP_LOAD) begin
							if (32'(voice_index) < VOICES) first_q <= 1'b1;
						end else if (since_q >= ((update_period_q == 16'd0) ? 16'd1
								: update_period_q)) begin
							state_q <= ucho_pkg::S_U_RD;
						end else begin
							since_q <= since_q + 16'd1;
							state_q <= ucho_pkg::S_G_RD;
						end
					end
				end
				ucho_pkg::S_U_RD:   state_q <= ucho_pkg::S_U_ADD;
				ucho_pkg::S_U_ADD:  state_q <= ucho_pkg::S_U_SQ;
				ucho_pkg::S_U_SQ:   state_q <= ucho_pkg::S_U_CUBE;
				ucho_pkg::S_U_CUBE: state_q <= ucho_pkg::S_U_H;
				ucho_pkg::S_U_H:    state_q <= ucho_pkg::S_U_AM;
				ucho_pkg::S_U_AM:   state_q <= ucho_pkg::S_U_PLO;
				ucho_pkg::S_U_PLO:  state_q <= ucho_pkg::S_U_PHI;
				ucho_pkg::S_U_PHI:  state_q <= ucho_pkg::S_U_SUM;
				ucho_pkg::S_U_SUM:  state_q <= ucho_pkg::S_U_WR;
				ucho_pkg::S_U_WR: begin
					if (k_q == last_k) begin
						// Period restarts: the counter becomes zero, then counts this sample.
						k_q     <= '0;
						first_q <= 1'b0;
						since_q <= 16'd1;
						state_q <= ucho_pkg::S_G_RD;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= ucho_pkg::S_U_RD;
					end
				end
				ucho_pkg::S_G_RD: state_q <= ucho_pkg::S_G_M0;
				ucho_pkg::S_G_M0: state_q <= ucho_pkg::S_G_M1;
				ucho_pkg::S_G_M1: begin
					cnt_q   <= '0;
					state_q <= ucho_pkg::S_G_DIV;
				end
				ucho_pkg::S_G_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd27) state_q <= ucho_pkg::S_G_ADR;
				end
				ucho_pkg::S_G_ADR: state_q <= ucho_pkg::S_G_R0;
				ucho_pkg::S_G_R0:  state_q <= ucho_pkg::S_G_R1;
				ucho_pkg::S_G_R1:  state_q <= ucho_pkg::S_G_M2;
				ucho_pkg::S_G_M2:  state_q <= ucho_pkg::S_G_M3;
				ucho_pkg::S_G_M3: begin
					if (k_q == last_k) begin
						state_q <= ucho_pkg::S_F_GAIN;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= ucho_pkg::S_G_RD;
					end
				end
				ucho_pkg::S_F_GAIN: state_q <= ucho_pkg::S_F_OUT;
				ucho_pkg::S_F_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= ysat;
						out_valid_q <= 1'b1;
						if (wi_q == LAST_ADDR) begin
							wi_q      <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wi_q <= wi_q + AW'(1);
						end
						state_q <= ucho_pkg::S_IDLE;
					end
				end
				default: state_q <= ucho_pkg::S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/ucho_check.sv @@
// Port-level checks for the unison chorus, attached by the bind below.
// Depends on unison_chorus port names; uses no package items.
`timescale 1ns / 1ps

module ucho_check #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_ready,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   op,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] sample_out
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("result changed while stalled");

	// A voice load never produces a result.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op && !out_valid |=> !out_valid)
		else $error("result after a voice load");

	// An audio sample keeps the block busy on the next cycle.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !op |=> !in_ready)
		else $error("item accepted during sample processing");

	// The configuration port never stalls.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind unison_chorus ucho_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_ucho_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_ready  (cfg_ready),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.op         (op),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out)
);
